// ===== hw/rtl/stroke_width_component_labeling_assert.svh =====
// assertion macros for the stroke width labeling block
`ifndef STROKE_WIDTH_COMPONENT_LABELING_ASSERT_SVH
`define STROKE_WIDTH_COMPONENT_LABELING_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SWCL_ASSERT_IMPL(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define SWCL_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);
`endif

// ===== hw/rtl/swcl_pkg.sv =====
// types and constants for the stroke width labeling block
package swcl_pkg;
  localparam logic [1:0] OP_PIXEL  = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  // reserved code, only frame_start acts
  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam logic [15:0] NO_STROKE = 16'hFFFF;
  localparam logic [10:0] WIDTH_RESET = 11'd640;
  // label table depth, tied to the 12 bit label fields
  localparam int MAX_LABELS = 4096;

  typedef enum logic [4:0] {
    S_IDLE, S_LBUF, S_NB, S_FIND_RD, S_FIND_WAIT, S_FIND_GP, S_FIND_GPW, S_FIND_WR,
    S_MERGE, S_ALLOC, S_OUT, S_FIN_RD, S_FIN_WAIT, S_FIN_GP, S_FIN_GPW, S_FIN_WR,
    S_Q_RD, S_Q_WAIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       take_item;
    logic       lbuf_rd;
    logic       nb_latch;
    logic [1:0] nb_sel;
    logic       tab_rd_cur;
    logic       tab_rd_gp;
    logic       tab_wr_halve;
    logic       find_step;
    logic       merge;
    logic       alloc;
    logic       pixel_commit;
    logic       fin_init;
    logic       fin_rd;
    logic       fin_gp;
    logic       fin_wr;
    logic       q_rd;
    logic       out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       nb_ok;
    logic       is_root;
    logic       fin_done;
  } status_t;

  // similar widths: both nonzero, no-stroke only to itself, max < 4*min
  function automatic logic similar(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    if (a == 16'd0 || b == 16'd0) return 1'b0;
    if (a == NO_STROKE || b == NO_STROKE) return a == b;
    return {2'b00, hi} < {lo, 2'b00};
  endfunction
endpackage

// ===== hw/rtl/swcl_stream_if.sv =====
// valid/ready channel interfaces
interface swcl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        frame_start;
  logic [15:0] stroke_width;
  logic [11:0] query_label;
  modport source (output valid, operation, frame_start, stroke_width, query_label,
                  input ready);
  modport sink (input valid, operation, frame_start, stroke_width, query_label,
                output ready);
endinterface

interface swcl_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] label;
  logic [12:0] region_count;
  logic        overflow;
  modport source (output valid, label, region_count, overflow, input ready);
  modport sink (input valid, label, region_count, overflow, output ready);
endinterface

interface swcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/swcl_ctrl.sv =====
// sequencer for pixel merging, renumbering and queries
module swcl_ctrl
  import swcl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_busy,
  input  status_t sts,
  output cmd_t    cmd
);
  state_t state, state_next;
  logic [1:0] nb, nb_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nb <= 2'd0;
    end else begin
      state <= state_next;
      nb <= nb_next;
    end
  end

  always_comb begin
    state_next = state;
    nb_next = nb;
    cmd = '0;
    cmd.nb_sel = nb;
    in_ready = (state == S_IDLE) && !out_busy;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !out_busy) begin
          cmd.take_item = 1'b1;
          state_next = S_LBUF;
        end
      end
      S_LBUF: begin
        unique case (sts.op)
          OP_PIXEL: begin
            cmd.lbuf_rd = 1'b1;
            nb_next = 2'd0;
            state_next = S_NB;
          end
          OP_FINISH: begin
            cmd.fin_init = 1'b1;
            state_next = S_FIN_RD;
          end
          OP_QUERY: state_next = S_Q_RD;
          default: begin
            cmd.out_load = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_NB: begin
        cmd.nb_latch = 1'b1;
        if (sts.nb_ok) state_next = S_FIND_RD;
        else if (nb == 2'd3) state_next = S_ALLOC;
        else nb_next = nb + 2'd1;
      end
      S_FIND_RD: begin
        cmd.tab_rd_cur = 1'b1;
        state_next = S_FIND_WAIT;
      end
      S_FIND_WAIT: begin
        if (sts.is_root) state_next = S_MERGE;
        else state_next = S_FIND_GP;
      end
      S_FIND_GP: begin
        cmd.tab_rd_gp = 1'b1;
        state_next = S_FIND_GPW;
      end
      S_FIND_GPW: state_next = S_FIND_WR;
      S_FIND_WR: begin
        cmd.tab_wr_halve = 1'b1;
        cmd.find_step = 1'b1;
        state_next = S_FIND_RD;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        if (nb == 2'd3) state_next = S_ALLOC;
        else begin
          nb_next = nb + 2'd1;
          state_next = S_NB;
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.pixel_commit = 1'b1;
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      S_FIN_RD: begin
        if (sts.fin_done) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.fin_rd = 1'b1;
          state_next = S_FIN_WAIT;
        end
      end
      S_FIN_WAIT: state_next = S_FIN_GP;
      S_FIN_GP: begin
        cmd.fin_gp = 1'b1;
        state_next = S_FIN_GPW;
      end
      S_FIN_GPW: state_next = S_FIN_WR;
      S_FIN_WR: begin
        cmd.fin_wr = 1'b1;
        state_next = S_FIN_RD;
      end
      S_Q_RD: begin
        cmd.q_rd = 1'b1;
        state_next = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/swcl_datapath.sv =====
// line buffers, parent table and label arithmetic
module swcl_datapath
  import swcl_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic [1:0]  operation,
  input  logic        frame_start,
  input  logic [15:0] stroke_width,
  input  logic [11:0] query_label,
  input  logic [10:0] image_width,
  output logic [11:0] res_label,
  output logic [12:0] res_count,
  output logic        res_overflow
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_LABELS);

  logic [15:0]   lb_w [MAX_WIDTH];
  logic [11:0]   lb_l [MAX_WIDTH];
  logic [LW-1:0] tab  [MAX_LABELS];

  logic [1:0]  op;
  logic [15:0] w;
  logic [11:0] q;
  logic [15:0] left_w, diag_w, up_w, ur_w, nbw;
  logic [11:0] left_l, diag_l, up_l, ur_l, nbl;
  logic [LW:0] next_label;
  logic [CW:0] col;
  logic        first_row, ovf;
  logic [LW:0] a, cur;
  logic        any;
  logic [LW-1:0] rd_data, par;
  logic [LW:0] k;
  logic [12:0] count;
  logic [11:0] lbl;
  logic [CW:0] eff_w;
  logic        has_left, has_up, has_ur, nb_f;

  always_comb begin
    if (image_width == 11'd0) eff_w = (CW+1)'(1);
    else if (32'(image_width) > MAX_WIDTH) eff_w = (CW+1)'(MAX_WIDTH);
    else eff_w = (CW+1)'(image_width);
  end

  assign has_left = col != '0;
  assign has_up = !first_row && (32'(col) < MAX_WIDTH);
  assign has_ur = has_up && (col + 1'b1 < eff_w) && (32'(col) + 1 < MAX_WIDTH);

  always_comb begin
    case (cmd.nb_sel)
      2'd0: begin nbw = left_w; nbl = left_l; nb_f = has_left; end
      2'd1: begin nbw = up_w; nbl = up_l; nb_f = has_up; end
      2'd2: begin nbw = diag_w; nbl = diag_l; nb_f = has_up && has_left; end
      default: begin nbw = ur_w; nbl = ur_l; nb_f = has_ur; end
    endcase
  end

  always_comb begin
    sts.op = op;
    sts.nb_ok = nb_f && similar(w, nbw) && ({1'b0, nbl} < 13'(next_label));
    sts.is_root = (a[LW] == 1'b1) || ({1'b0, rd_data} == a);
    sts.fin_done = !(k < next_label);
  end

  // table read port, registered
  always_ff @(posedge clk) begin
    if (cmd.tab_rd_cur) rd_data <= tab[a[LW-1:0]];
    else if (cmd.tab_rd_gp || cmd.fin_gp) rd_data <= tab[rd_data];
    else if (cmd.fin_rd) rd_data <= tab[k[LW-1:0]];
    else if (cmd.q_rd) rd_data <= tab[q[LW-1:0]];
  end

  // table write port
  always_ff @(posedge clk) begin
    if (cmd.tab_wr_halve) tab[a[LW-1:0]] <= rd_data;
    else if (cmd.merge && any && !a[LW]) begin
      if (cur < a) tab[a[LW-1:0]] <= cur[LW-1:0];
      else if (!cur[LW]) tab[cur[LW-1:0]] <= a[LW-1:0];
    end else if (cmd.alloc && !any && !next_label[LW])
      tab[next_label[LW-1:0]] <= next_label[LW-1:0];
    else if (cmd.fin_wr)
      tab[k[LW-1:0]] <= (par == k[LW-1:0]) ? count[LW-1:0] : rd_data;
  end

  // line buffer reads and writes
  always_ff @(posedge clk) begin
    if (cmd.lbuf_rd) begin
      up_w <= lb_w[col[CW-1:0]];
      up_l <= lb_l[col[CW-1:0]];
      ur_w <= lb_w[col[CW-1:0] + 1'b1];
      ur_l <= lb_l[col[CW-1:0] + 1'b1];
    end
    if (cmd.pixel_commit && (32'(col) < MAX_WIDTH)) begin
      lb_w[col[CW-1:0]] <= w;
      lb_l[col[CW-1:0]] <= lbl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op <= operation;
      w  <= stroke_width;
      q  <= query_label;
    end
    if (cmd.nb_latch) a <= {1'b0, nbl[LW-1:0]} | ((LW+1)'(nbl) & (LW+1)'(1 << LW));
    if (cmd.find_step) a <= {1'b0, rd_data};
    if (cmd.fin_rd) par <= '0;
    if (cmd.fin_gp) par <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_label <= '0;
      col <= '0;
      first_row <= 1'b1;
      ovf <= 1'b0;
      left_w <= '0; left_l <= '0; diag_w <= '0; diag_l <= '0;
      any <= 1'b0; cur <= '0; k <= '0; count <= '0; lbl <= '0;
    end else begin
      if (cmd.take_item && frame_start) begin
        next_label <= '0; col <= '0; first_row <= 1'b1; ovf <= 1'b0;
        left_w <= '0; left_l <= '0; diag_w <= '0; diag_l <= '0;
      end
      if (cmd.lbuf_rd) any <= 1'b0;
      if (cmd.merge) begin
        if (!any) begin
          cur <= a; any <= 1'b1;
        end else if (!(cur < a)) cur <= a;
      end
      if (cmd.alloc) begin
        if (any) lbl <= 12'(cur);
        else if (!next_label[LW]) begin
          lbl <= 12'(next_label);
          next_label <= next_label + 1'b1;
        end else begin
          lbl <= 12'(MAX_LABELS - 1);
          ovf <= 1'b1;
        end
      end
      if (cmd.pixel_commit) begin
        if (32'(col) < MAX_WIDTH) begin
          diag_w <= up_w; diag_l <= up_l;
        end
        left_w <= w; left_l <= lbl;
        if (col + 1'b1 >= eff_w) begin
          col <= '0; first_row <= 1'b0;
        end else col <= col + 1'b1;
      end
      if (cmd.fin_init) begin
        k <= '0; count <= '0;
      end
      if (cmd.fin_wr) begin
        if (par == k[LW-1:0]) count <= count + 1'b1;
        k <= k + 1'b1;
      end
    end
  end

  // par holds parent of k after fin_gp, rd_data then holds grandparent
  always_comb begin
    res_overflow = ovf;
    res_label = '0;
    res_count = '0;
    case (op)
      OP_PIXEL: res_label = lbl;
      OP_FINISH: res_count = count;
      OP_QUERY: res_label = ({1'b0, q} < 13'(next_label)) ? 12'(rd_data) : 12'd0;
      default: res_label = '0;
    endcase
  end
endmodule

// ===== hw/rtl/stroke_width_component_labeling.sv =====
// top level of the stroke width connected-component labeling block
// usage:
//   in   : one transfer per item (pixel, finish or query) in raster order
//   out  : exactly one result transfer per accepted item
//   cfg  : image_width write, only while the block is idle
// operation:
//   one item is processed at a time; the sequencer walks the four
//   neighbors and runs a find with path halving per similar one, each
//   find step reading the parent table twice and writing it once
//   a pixel with no similar neighbor checks all four neighbors, then
//   allocates a label; each similar neighbor adds a find and a merge
//   finish sweeps every allocated label, renumbering roots densely
//   a query returns the table entry of its label, zero if unallocated
// reset clears position, label count and overflow; image_width becomes 640
// the line buffers and parent table are not cleared
// a stalled receiver holds the result register and blocks new items
module stroke_width_component_labeling
  import swcl_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024
) (
  input logic clk,
  input logic rst,
  swcl_in_if.sink    in_ch,
  swcl_out_if.source out_ch,
  swcl_cfg_if.sink   cfg
);
  cmd_t        cmd;
  status_t     sts;
  logic [10:0] image_width;
  logic [11:0] res_label;
  logic [12:0] res_count;
  logic        res_overflow;
  logic        out_valid;

  // configuration register, always ready
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) image_width <= WIDTH_RESET;
    else if (cfg.valid) image_width <= cfg.data;
  end

  swcl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(out_valid), .sts(sts), .cmd(cmd)
  );

  swcl_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(in_ch.operation), .frame_start(in_ch.frame_start),
    .stroke_width(in_ch.stroke_width), .query_label(in_ch.query_label),
    .image_width(image_width), .res_label(res_label), .res_count(res_count),
    .res_overflow(res_overflow)
  );

  // output register, holds until transfer
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
    if (cmd.out_load) begin
      out_ch.label <= res_label;
      out_ch.region_count <= res_count;
      out_ch.overflow <= res_overflow;
    end
  end
  assign out_ch.valid = out_valid;
endmodule

// ===== hw/rtl/swcl_checker.sv =====
// port level checks for the labeling block
`include "stroke_width_component_labeling_assert.svh"
module swcl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [11:0] out_label,
  input logic [12:0] out_count
);
  `SWCL_ASSERT_IMPL(a_no_accept_while_full, out_valid, !in_ready, "input taken while result pending")
  `SWCL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_label), "stalled result changed")
  `SWCL_ASSERT_NEXT(a_not_ready_after_accept, in_valid && in_ready, !in_ready, "back to back accept")
  `SWCL_ASSERT_IMPL(a_count_label, out_valid && out_count != 13'd0, out_label == 12'd0, "finish result with label")
endmodule

bind stroke_width_component_labeling swcl_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_label(out_ch.label), .out_count(out_ch.region_count)
);

// ===== dv/swcl_label_checker.sv =====
// result checker for the stroke width labeling block: predicts every result and compares it
`timescale 1ns / 1ps
module swcl_label_checker
  import swcl_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LABELS = 4096
) (
  input  logic clk,
  input  logic rst,
  swcl_in_if   in_ch,
  swcl_out_if  out_ch,
  swcl_cfg_if  cfg_ch,
  output int   mismatches,
  output int   outstanding
);
  typedef struct {
    logic [11:0] label;
    logic [12:0] region_count;
    logic        overflow;
  } label_result_t;

  label_result_t expected_results[$];

  // predictor state
  logic [10:0] row_width_reg;
  int unsigned line_widths[MAX_WIDTH];
  int unsigned line_labels[MAX_WIDTH];
  int unsigned parent[MAX_LABELS];
  int unsigned left_w, left_l, diag_w, diag_l;
  int unsigned labels_used, column, ovf_flag;
  bit          top_row;

  function automatic void clear_frame();
    labels_used = 0;
    ovf_flag    = 0;
    column      = 0;
    top_row     = 1'b1;
    left_w      = 0;
    left_l      = 0;
    diag_w      = 0;
    diag_l      = 0;
  endfunction

  function automatic bit widths_alike(int unsigned a, int unsigned b);
    int unsigned hi, lo;
    if (a == 0 || b == 0) return 1'b0;
    if (a == NO_STROKE || b == NO_STROKE) return a == b;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    return hi < 4 * lo;
  endfunction

  // root search with path halving
  function automatic int unsigned find_root(int unsigned a);
    while (a < MAX_LABELS && parent[a] != a) begin
      parent[a] = parent[parent[a]];
      a = parent[a];
    end
    return a;
  endfunction

  function automatic int unsigned label_pixel(int unsigned w);
    int unsigned eff, col, cur, lbl, r;
    int unsigned nw[4], nl[4];
    bit          fl[4];
    bit          has_left, has_up, has_ur, found;
    eff = (row_width_reg == 0) ? 1 : (row_width_reg > MAX_WIDTH) ? MAX_WIDTH : row_width_reg;
    col = column;
    has_left = col > 0;
    has_up = !top_row && col < MAX_WIDTH;
    has_ur = has_up && col + 1 < eff && col + 1 < MAX_WIDTH;
    cur = 0;
    found = 1'b0;
    nw[0] = left_w;
    nl[0] = left_l;
    fl[0] = has_left;
    nw[1] = has_up ? line_widths[col] : 0;
    nl[1] = has_up ? line_labels[col] : 0;
    fl[1] = has_up;
    nw[2] = diag_w;
    nl[2] = diag_l;
    fl[2] = has_up && has_left;
    nw[3] = has_ur ? line_widths[col + 1] : 0;
    nl[3] = has_ur ? line_labels[col + 1] : 0;
    fl[3] = has_ur;
    // left, up, up-left, up-right; keep the smaller root
    for (int k = 0; k < 4; k++) begin
      if (fl[k] && widths_alike(w, nw[k]) && nl[k] < labels_used) begin
        r = find_root(nl[k]);
        if (!found) begin
          cur = r;
          found = 1'b1;
        end else if (cur < r) begin
          parent[r] = cur;
        end else begin
          parent[cur] = r;
          cur = r;
        end
      end
    end
    if (found) begin
      lbl = cur;
    end else if (labels_used < MAX_LABELS) begin
      lbl = labels_used;
      parent[lbl] = lbl;
      labels_used++;
    end else begin
      lbl = MAX_LABELS - 1;
      ovf_flag = 1;
    end
    if (col < MAX_WIDTH) begin
      diag_w = line_widths[col];
      diag_l = line_labels[col];
      line_widths[col] = w;
      line_labels[col] = lbl;
    end
    left_w = w;
    left_l = lbl;
    if (col + 1 >= eff) begin
      column = 0;
      top_row = 1'b0;
    end else begin
      column = col + 1;
    end
    return lbl;
  endfunction

  // dense renumbering of roots in ascending order
  function automatic int unsigned renumber_roots();
    int unsigned count;
    count = 0;
    for (int unsigned k = 0; k < labels_used && k < MAX_LABELS; k++) begin
      if (parent[k] == k) begin
        parent[k] = count;
        count++;
      end else begin
        parent[k] = parent[parent[k]];
      end
    end
    return count;
  endfunction

  function automatic label_result_t predict_item(logic [1:0] op, logic fs, logic [15:0] w,
                                                 logic [11:0] q);
    label_result_t res;
    res = '{default: '0};
    if (fs) clear_frame();
    case (op)
      OP_PIXEL:  res.label = 12'(label_pixel(w));
      OP_FINISH: res.region_count = 13'(renumber_roots());
      OP_QUERY:  res.label = (q < labels_used) ? 12'(parent[q]) : 12'd0;
      default: ;
    endcase
    res.overflow = ovf_flag[0];
    return res;
  endfunction

  always @(posedge clk) begin
    label_result_t exp_r;
    if (rst) begin
      row_width_reg = WIDTH_RESET;
      clear_frame();
      expected_results.delete();
      mismatches <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) row_width_reg = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        expected_results.insert(expected_results.size(),
                                predict_item(in_ch.operation, in_ch.frame_start,
                                             in_ch.stroke_width, in_ch.query_label));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer: label %0d", out_ch.label);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.label !== exp_r.label || out_ch.region_count !== exp_r.region_count ||
              out_ch.overflow !== exp_r.overflow) begin
            if (mismatches < 10)
              $display("mismatch: label %0d/%0d count %0d/%0d overflow %0d/%0d (exp/act)",
                       exp_r.label, out_ch.label, exp_r.region_count, out_ch.region_count,
                       exp_r.overflow, out_ch.overflow);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    outstanding <= expected_results.size();
  end
endmodule

// ===== dv/stroke_width_component_labeling_test.sv =====
// testbench top for the stroke width labeling block: stimulus, handshake idling and verdict
`timescale 1ns / 1ps
module stroke_width_component_labeling_test;
  import swcl_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RANDOM_ITEMS   = 1300;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   items_sent;
  int   idle_cycles;
  bit   quiet;        // no idling in the closing stretch
  bit   ended;        // leftover expectations at the end

  swcl_in_if  in_ch();
  swcl_out_if out_ch();
  swcl_cfg_if cfg_ch();

  stroke_width_component_labeling u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // watches all three channels, predicts and compares
  swcl_label_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: any cycle with no transfer anywhere counts toward the limit
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off so the block backs up its input
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && items_sent >= 300) begin
        // long stall while the sender keeps offering items
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        held = 1'b1;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // one item transfer, with an occasional idle burst in front of it
  task automatic send_item(logic [1:0] op, logic fs, logic [15:0] w, logic [11:0] q);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.frame_start  <= fs;
    in_ch.stroke_width <= w;
    in_ch.query_label  <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering and let every expected result come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // image_width write, only with the block idle
  task automatic write_row_width(logic [10:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // width palette: clusters that merge, background, zero and raw values
  function automatic logic [15:0] pick_stroke();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return NO_STROKE;
      7: return 16'($urandom());
      8: return 16'd1;
      9: return 16'hFFFE;
      default: return 16'($urandom_range(40, 200));
    endcase
  endfunction

  // one frame in raster order with noise, then finish and queries
  task automatic run_frame(int eff_width);
    int rows;
    rows = $urandom_range(1, 6);
    for (int p = 0; p < rows * eff_width; p++) begin
      if ($urandom_range(0, 29) == 0) begin
        // noise: unknown operation or a stray query, frame_start low
        if ($urandom_range(0, 1))
          send_item(OP_NONE, 1'b0, 16'($urandom()), 12'($urandom()));
        else
          send_item(OP_QUERY, 1'b0, 16'($urandom()), 12'($urandom_range(0, 40)));
      end
      // a rare restart in mid frame breaks the sequence
      send_item(OP_PIXEL, p == 0 || $urandom_range(0, 99) == 0, pick_stroke(),
                12'($urandom()));
    end
    if ($urandom_range(0, 3) == 0) send_item(OP_QUERY, 1'b0, 16'd0, 12'($urandom_range(0, 30)));
    send_item(OP_FINISH, 1'b0, 16'($urandom()), 12'($urandom()));
    repeat ($urandom_range(1, 6))
      send_item(OP_QUERY, 1'b0, 16'($urandom()),
                $urandom_range(0, 1) ? 12'($urandom_range(0, 60)) : 12'($urandom()));
    if ($urandom_range(0, 4) == 0) begin
      // pixels on the renumbered table, then a second renumbering
      repeat ($urandom_range(1, 4)) send_item(OP_PIXEL, 1'b0, pick_stroke(), 12'd0);
      send_item(OP_FINISH, 1'b0, 16'd0, 12'd0);
      send_item(OP_QUERY, 1'b0, 16'd0, 12'($urandom_range(0, 20)));
    end
  endtask

  initial begin
    logic [10:0] row_widths[$];
    logic [10:0] cfg_val;
    int          eff;
    int          random_start;
    int          frames;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_PIXEL;
    in_ch.frame_start  = 1'b0;
    in_ch.stroke_width = '0;
    in_ch.query_label  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    items_sent         = 0;
    quiet              = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset width, background, extremes, every operation
    send_item(OP_PIXEL, 1'b1, 16'd0, 12'd0);
    send_item(OP_PIXEL, 1'b0, NO_STROKE, 12'hFFF);
    send_item(OP_PIXEL, 1'b0, NO_STROKE, 12'd0);
    send_item(OP_PIXEL, 1'b0, 16'd1, 12'd0);
    send_item(OP_PIXEL, 1'b0, 16'd3, 12'd0);       // 3 < 4*1: joins
    send_item(OP_PIXEL, 1'b0, 16'd12, 12'd0);      // 12 == 4*3: no join
    send_item(OP_PIXEL, 1'b0, 16'hFFFE, 12'd0);
    send_item(OP_QUERY, 1'b0, 16'd0, 12'd3);       // before finish: raw parent
    send_item(OP_NONE, 1'b0, 16'hFFFF, 12'hFFF);
    send_item(OP_FINISH, 1'b0, 16'd0, 12'd0);
    send_item(OP_QUERY, 1'b0, 16'd0, 12'd2);
    send_item(OP_QUERY, 1'b0, 16'd0, 12'hFFF);     // out of range
    send_item(OP_PIXEL, 1'b0, 16'd13, 12'd0);      // after finish
    send_item(OP_FINISH, 1'b0, 16'd0, 12'd0);
    send_item(OP_QUERY, 1'b1, 16'd0, 12'd0);       // frame_start on a query
    send_item(OP_NONE, 1'b1, 16'd0, 12'd0);

    // row width above the maximum acts as 1024
    write_row_width(11'h7FF);
    for (int p = 0; p < 40; p++)
      send_item(OP_PIXEL, p == 0, pick_stroke(), 12'($urandom()));
    send_item(OP_FINISH, 1'b0, 16'd0, 12'd0);
    send_item(OP_QUERY, 1'b0, 16'd0, 12'd5);
    send_item(OP_QUERY, 1'b0, 16'd0, 12'hFFF);

    // random phases over a range of row widths, zero and one among them
    row_widths = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd5, 11'd8, 11'd13, 11'd16, 11'd31};
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      cfg_val = row_widths[$urandom_range(0, row_widths.size() - 1)];
      write_row_width(cfg_val);
      eff = (cfg_val == 0) ? 1 : cfg_val;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames && items_sent - random_start < RANDOM_ITEMS; f++) begin
        if (items_sent - random_start > RANDOM_ITEMS - 300) quiet = 1'b1;
        run_frame(eff);
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    // wait for the last results, bounded
    for (int c = 0; c < WATCHDOG_LIMIT && outstanding != 0; c++) @(posedge clk);
    ended = outstanding != 0;
    repeat (50) @(posedge clk);
    if (mismatches == 0 && !ended && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
